// ===== hw/rtl/riscv_subset_instruction_execute_macros.svh =====
// Assertion macros used by the checker file of the execute block.
// No dependencies; include by bare file name.
`ifndef RISCV_SUBSET_INSTRUCTION_EXECUTE_MACROS_SVH
`define RISCV_SUBSET_INSTRUCTION_EXECUTE_MACROS_SVH

// same-cycle implication, quiet while reset is asserted (active low)
`define RSIE_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is asserted (active low)
`define RSIE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rsie_pkg.sv =====
// Shared types and constants of the RV64I subset execute block.
// No dependencies; used by every module but rsie_ram through scoped names.
package rsie_pkg;

    localparam int XLEN       = 64;
    localparam int ILEN       = 32;
    localparam int PC_W       = 32;
    localparam int REG_COUNT  = 32;
    localparam int REG_AW     = 5;
    localparam int INSTR_STEP = 4;

    // data memory: word indexed, depth is a power of two
    localparam int DMEM_AW    = 10;
    localparam int DMEM_WORDS = 1 << DMEM_AW;
    localparam int MIDX_W     = 10;

    // result queue
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_DEPTH = 1 << OUTQ_AW;

    // instruction field positions
    localparam int RD_LSB  = 7;
    localparam int F3_LSB  = 12;
    localparam int RS1_LSB = 15;
    localparam int RS2_LSB = 20;
    localparam int F7_LSB  = 25;

    typedef enum logic [6:0] {
        OP_LOAD   = 7'd3,
        OP_IMM    = 7'd19,
        OP_STORE  = 7'd35,
        OP_REG    = 7'd51,
        OP_BRANCH = 7'd99
    } opcode_t;

    localparam logic [2:0] F3_ADD   = 3'd0;
    localparam logic [2:0] F3_SLL   = 3'd1;
    localparam logic [2:0] F3_DWORD = 3'd3;
    localparam logic [2:0] F3_XOR   = 3'd4;
    localparam logic [2:0] F3_SRL   = 3'd5;
    localparam logic [2:0] F3_OR    = 3'd6;
    localparam logic [2:0] F3_AND   = 3'd7;

    localparam logic [2:0] F3_BEQ = 3'd0;
    localparam logic [2:0] F3_BNE = 3'd1;
    localparam logic [2:0] F3_BLT = 3'd4;
    localparam logic [2:0] F3_BGE = 3'd5;

    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_SUB  = 7'd32;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_LOAD  = 2'd1,
        MEM_STORE = 2'd2
    } mem_access_t;

    // decoded and executed instruction, before the load data is known
    typedef struct packed {
        logic [PC_W-1:0]    next_pc;
        logic               wr_en;
        logic [REG_AW-1:0]  rd;
        logic [XLEN-1:0]    value;
        mem_access_t        access;
        logic [DMEM_AW-1:0] addr;
        logic [XLEN-1:0]    store_data;
        logic               unsupported;
    } exec_result_t;

    // result transaction, last field in the low bits
    typedef struct packed {
        logic               unsupported;
        logic [MIDX_W-1:0]  memory_index;
        mem_access_t        memory_access;
        logic [XLEN-1:0]    written_value;
        logic [REG_AW-1:0]  dest_register;
        logic               reg_written;
        logic [PC_W-1:0]    next_pc;
    } result_t;

    localparam int RESULT_W   = $bits(result_t);
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;
    localparam int S_TDATA_W  = ILEN;

endpackage

// ===== hw/rtl/rsie_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rsie_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/rsie_exec.sv =====
// Decode, ALU, address generation and branch resolution for one instruction.
// Depends on rsie_pkg.
module rsie_exec (
    input  logic [rsie_pkg::ILEN-1:0]  instr,
    input  logic [rsie_pkg::PC_W-1:0]  pc,
    input  logic [rsie_pkg::XLEN-1:0]  op_a,
    input  logic [rsie_pkg::XLEN-1:0]  op_b,
    output rsie_pkg::exec_result_t     res
);

    logic [2:0]                  f3;
    logic [6:0]                  f7;
    logic [rsie_pkg::REG_AW-1:0] rd;
    logic [rsie_pkg::XLEN-1:0]   imm_i;
    logic [rsie_pkg::XLEN-1:0]   imm_s;
    logic [rsie_pkg::PC_W-1:0]   imm_b;
    logic [5:0]                  sh_r;
    logic [5:0]                  sh_i;
    logic                        top_zero;
    logic [rsie_pkg::XLEN-1:0]   addr_sum;
    logic                        taken;
    logic                        wr;
    logic                        bad;

    assign f3       = instr[rsie_pkg::F3_LSB +: 3];
    assign f7       = instr[rsie_pkg::F7_LSB +: 7];
    assign rd       = instr[rsie_pkg::RD_LSB +: rsie_pkg::REG_AW];
    assign imm_i    = {{(rsie_pkg::XLEN-12){instr[31]}}, instr[31:20]};
    assign imm_s    = {{(rsie_pkg::XLEN-12){instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b    = {{(rsie_pkg::PC_W-13){instr[31]}}, instr[31], instr[7],
                       instr[30:25], instr[11:8], 1'b0};
    assign sh_r     = op_b[5:0];
    assign sh_i     = instr[25:20];
    assign top_zero = (instr[31:26] == 6'd0);
    assign addr_sum = op_a + ((rsie_pkg::opcode_t'(instr[6:0]) == rsie_pkg::OP_STORE)
                              ? imm_s : imm_i);

    always_comb begin
        res            = '0;
        res.next_pc    = pc + rsie_pkg::PC_W'(rsie_pkg::INSTR_STEP);
        res.access     = rsie_pkg::MEM_NONE;
        res.store_data = op_b;
        wr             = 1'b0;
        bad            = 1'b0;
        taken          = 1'b0;
        unique case (rsie_pkg::opcode_t'(instr[6:0]))
            rsie_pkg::OP_REG: begin
                wr = 1'b1;
                unique case (f3)
                    rsie_pkg::F3_ADD: begin
                        if (f7 == rsie_pkg::F7_BASE)     res.value = op_a + op_b;
                        else if (f7 == rsie_pkg::F7_SUB) res.value = op_a - op_b;
                        else                             bad = 1'b1;
                    end
                    rsie_pkg::F3_SLL: begin
                        res.value = op_a << sh_r;
                        bad       = (f7 != rsie_pkg::F7_BASE);
                    end
                    rsie_pkg::F3_SRL: begin
                        res.value = op_a >> sh_r;
                        bad       = (f7 != rsie_pkg::F7_BASE);
                    end
                    rsie_pkg::F3_XOR: begin
                        res.value = op_a ^ op_b;
                        bad       = (f7 != rsie_pkg::F7_BASE);
                    end
                    rsie_pkg::F3_OR: begin
                        res.value = op_a | op_b;
                        bad       = (f7 != rsie_pkg::F7_BASE);
                    end
                    rsie_pkg::F3_AND: begin
                        res.value = op_a & op_b;
                        bad       = (f7 != rsie_pkg::F7_BASE);
                    end
                    default: bad = 1'b1;
                endcase
            end
            rsie_pkg::OP_IMM: begin
                wr = 1'b1;
                unique case (f3)
                    rsie_pkg::F3_ADD: res.value = op_a + imm_i;
                    rsie_pkg::F3_SLL: begin
                        res.value = op_a << sh_i;
                        bad       = !top_zero;
                    end
                    rsie_pkg::F3_SRL: begin
                        res.value = op_a >> sh_i;
                        bad       = !top_zero;
                    end
                    rsie_pkg::F3_XOR: res.value = op_a ^ imm_i;
                    rsie_pkg::F3_OR:  res.value = op_a | imm_i;
                    rsie_pkg::F3_AND: res.value = op_a & imm_i;
                    default:          bad = 1'b1;
                endcase
            end
            rsie_pkg::OP_LOAD: begin
                if (f3 == rsie_pkg::F3_DWORD) begin
                    wr         = 1'b1;
                    res.access = rsie_pkg::MEM_LOAD;
                    res.addr   = addr_sum[rsie_pkg::DMEM_AW-1:0];
                end else begin
                    bad = 1'b1;
                end
            end
            rsie_pkg::OP_STORE: begin
                if (f3 == rsie_pkg::F3_DWORD) begin
                    res.access = rsie_pkg::MEM_STORE;
                    res.addr   = addr_sum[rsie_pkg::DMEM_AW-1:0];
                end else begin
                    bad = 1'b1;
                end
            end
            rsie_pkg::OP_BRANCH: begin
                unique case (f3)
                    rsie_pkg::F3_BEQ: taken = (op_a == op_b);
                    rsie_pkg::F3_BNE: taken = (op_a != op_b);
                    rsie_pkg::F3_BLT: taken = ($signed(op_a) <  $signed(op_b));
                    rsie_pkg::F3_BGE: taken = ($signed(op_a) >= $signed(op_b));
                    default:          bad   = 1'b1;
                endcase
                if (taken) begin
                    res.next_pc = pc + imm_b;
                end
            end
            default: bad = 1'b1;
        endcase

        // x0 and rejected encodings leave the register file alone
        res.wr_en       = wr && !bad && (rd != '0);
        res.rd          = res.wr_en ? rd : '0;
        res.unsupported = bad;
        if (!res.wr_en) begin
            res.value = '0;
        end
    end

endmodule

// ===== hw/rtl/rsie_outq.sv =====
// Result queue between the writeback stage and the master stream port.
// Depends on rsie_pkg.
module rsie_outq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push_valid,
    input  rsie_pkg::result_t           push_data,
    input  logic                        pop_ready,
    output logic                        pop_valid,
    output rsie_pkg::result_t           pop_data,
    output logic [rsie_pkg::OUTQ_AW:0]  level
);

    rsie_pkg::result_t               slot_reg [rsie_pkg::OUTQ_DEPTH];
    logic [rsie_pkg::OUTQ_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [rsie_pkg::OUTQ_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [rsie_pkg::OUTQ_AW:0]      count_reg, count_next;
    logic                            pop;

    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign level     = count_reg;
    assign pop       = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + (push_valid ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (pop ? 1'b1 : 1'b0);
        count_next  = count_reg;
        if (push_valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push_valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/riscv_subset_instruction_execute.sv =====
// RV64I subset execute block: one instruction word in, one result transaction out.
//
// Input stream (s_*): each transaction carries a 32-bit instruction fetched at
// the current PC. Output stream (m_*): one result transaction per instruction,
// in order: next PC, register write, memory access and unsupported flag.
// cfg_we/cfg_wdata set the start PC; a write before the first instruction after
// reset also loads the PC, later writes have no visible effect until reset.
//
// Pipeline: accept (register file read) -> EX (decode, ALU, branch, data
// memory read or write) -> MEM (load data, register writeback) -> result queue.
// A result passes the EX and MEM registers and the result queue before it shows on m_*.
// Throughput is one instruction per cycle while s_tready is high: EX forwards
// from MEM (including load data straight off the data memory port) and from
// the write retired on the previous edge, so dependent instructions never wait.
//
// Reset (aresetn low, synchronous): PC to 0, register file reads as zero via
// per-entry valid bits, then a clearing pass zeroes the 1024-word data memory,
// one word per cycle; s_tready stays low until the pass ends.
// Receiver stall: results collect in a 4-entry queue; s_tready drops once the
// queue plus the instructions still in flight would fill it.
module riscv_subset_instruction_execute (
    input  logic                             aclk,
    input  logic                             aresetn,
    // instruction stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rsie_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] instruction_word
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] next_pc, [32] reg_written, [37:33] dest_register,
    // [101:38] written_value, [103:102] memory_access,
    // [113:104] memory_index, [114] unsupported, [119:115] zero
    output logic [rsie_pkg::M_TDATA_W-1:0]   m_tdata,
    // start PC register
    input  logic                             cfg_we,
    input  logic [rsie_pkg::PC_W-1:0]        cfg_wdata
);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic                           s_accept;
    logic                           clr_active_reg, clr_active_next;
    logic [rsie_pkg::DMEM_AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [rsie_pkg::PC_W-1:0]      pc_reg, pc_next;
    logic                           started_reg, started_next;

    // EX stage
    logic                           ex_valid_reg;
    logic [rsie_pkg::ILEN-1:0]      ex_instr_reg;
    rsie_pkg::exec_result_t         ex_res;
    logic [rsie_pkg::XLEN-1:0]      ex_op [2];
    logic [rsie_pkg::REG_AW-1:0]    ex_rs [2];

    // MEM / writeback stage
    logic                           mem_valid_reg;
    rsie_pkg::exec_result_t         mem_res_reg;
    logic [rsie_pkg::XLEN-1:0]      wb_value;
    logic                           rf_we;

    // write retired on the last edge, for the read made on that same edge
    logic                           byp_valid_reg;
    logic [rsie_pkg::REG_AW-1:0]    byp_rd_reg;
    logic [rsie_pkg::XLEN-1:0]      byp_value_reg;

    // register file entries written since reset; others read as zero
    logic [rsie_pkg::REG_COUNT-1:0] rf_valid_reg;

    // memories
    logic [rsie_pkg::XLEN-1:0]      rf_q [2];
    logic                           dm_we;
    logic [rsie_pkg::DMEM_AW-1:0]   dm_waddr;
    logic [rsie_pkg::XLEN-1:0]      dm_wdata;
    logic                           dm_re;
    logic [rsie_pkg::XLEN-1:0]      dm_rdata;

    // result queue
    rsie_pkg::result_t              wb_result;
    rsie_pkg::result_t              q_data;
    logic [rsie_pkg::OUTQ_AW:0]     q_level;
    logic [rsie_pkg::OUTQ_AW+1:0]   occupancy;

    // ---------------------------------------------------------------
    // Input handshake: credit covers EX, MEM and the queue
    // ---------------------------------------------------------------
    assign occupancy = (rsie_pkg::OUTQ_AW+2)'(q_level)
                     + (rsie_pkg::OUTQ_AW+2)'(ex_valid_reg)
                     + (rsie_pkg::OUTQ_AW+2)'(mem_valid_reg);
    assign s_tready  = !clr_active_reg
                     && (occupancy < (rsie_pkg::OUTQ_AW+2)'(rsie_pkg::OUTQ_DEPTH));
    assign s_accept  = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Register file: two copies give two read ports, written together
    // ---------------------------------------------------------------
    assign rf_we = mem_valid_reg && mem_res_reg.wr_en;

    rsie_ram #(
        .WIDTH (rsie_pkg::XLEN),
        .DEPTH (rsie_pkg::REG_COUNT)
    ) u_rf_a (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (mem_res_reg.rd),
        .wdata (wb_value),
        .re    (s_accept),
        .raddr (s_tdata[rsie_pkg::RS1_LSB +: rsie_pkg::REG_AW]),
        .rdata (rf_q[0])
    );

    rsie_ram #(
        .WIDTH (rsie_pkg::XLEN),
        .DEPTH (rsie_pkg::REG_COUNT)
    ) u_rf_b (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (mem_res_reg.rd),
        .wdata (wb_value),
        .re    (s_accept),
        .raddr (s_tdata[rsie_pkg::RS2_LSB +: rsie_pkg::REG_AW]),
        .rdata (rf_q[1])
    );

    // ---------------------------------------------------------------
    // EX: operand forwarding, newest first
    // ---------------------------------------------------------------
    assign ex_rs[0] = ex_instr_reg[rsie_pkg::RS1_LSB +: rsie_pkg::REG_AW];
    assign ex_rs[1] = ex_instr_reg[rsie_pkg::RS2_LSB +: rsie_pkg::REG_AW];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (rf_we && (mem_res_reg.rd == ex_rs[k])) begin
                ex_op[k] = wb_value;
            end else if (byp_valid_reg && (byp_rd_reg == ex_rs[k])) begin
                ex_op[k] = byp_value_reg;
            end else if (rf_valid_reg[ex_rs[k]]) begin
                ex_op[k] = rf_q[k];
            end else begin
                ex_op[k] = '0;
            end
        end
    end

    rsie_exec u_exec (
        .instr (ex_instr_reg),
        .pc    (pc_reg),
        .op_a  (ex_op[0]),
        .op_b  (ex_op[1]),
        .res   (ex_res)
    );

    // ---------------------------------------------------------------
    // Data memory: clearing pass owns the write port after reset
    // ---------------------------------------------------------------
    assign dm_we    = clr_active_reg
                    || (ex_valid_reg && (ex_res.access == rsie_pkg::MEM_STORE));
    assign dm_waddr = clr_active_reg ? clr_addr_reg : ex_res.addr;
    assign dm_wdata = clr_active_reg ? '0 : ex_res.store_data;
    assign dm_re    = ex_valid_reg && (ex_res.access == rsie_pkg::MEM_LOAD);

    rsie_ram #(
        .WIDTH (rsie_pkg::XLEN),
        .DEPTH (rsie_pkg::DMEM_WORDS)
    ) u_dmem (
        .aclk  (aclk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (dm_re),
        .raddr (ex_res.addr),
        .rdata (dm_rdata)
    );

    // ---------------------------------------------------------------
    // MEM / writeback
    // ---------------------------------------------------------------
    assign wb_value = (mem_res_reg.access == rsie_pkg::MEM_LOAD) ? dm_rdata
                                                                 : mem_res_reg.value;

    always_comb begin
        wb_result.next_pc       = mem_res_reg.next_pc;
        wb_result.reg_written   = mem_res_reg.wr_en;
        wb_result.dest_register = mem_res_reg.rd;
        wb_result.written_value = mem_res_reg.wr_en ? wb_value : '0;
        wb_result.memory_access = mem_res_reg.access;
        wb_result.memory_index  = rsie_pkg::MIDX_W'(mem_res_reg.addr);
        wb_result.unsupported   = mem_res_reg.unsupported;
    end

    rsie_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (mem_valid_reg),
        .push_data  (wb_result),
        .pop_ready  (m_tready),
        .pop_valid  (m_tvalid),
        .pop_data   (q_data),
        .level      (q_level)
    );

    assign m_tdata = rsie_pkg::M_TDATA_W'(q_data);

    // ---------------------------------------------------------------
    // PC, start address and clearing pass
    // ---------------------------------------------------------------
    always_comb begin
        pc_next      = pc_reg;
        started_next = started_reg;
        if (ex_valid_reg) begin
            pc_next      = ex_res.next_pc;
            started_next = 1'b1;
        end else if (cfg_we && !started_reg) begin
            pc_next = cfg_wdata;
        end
    end

    always_comb begin
        clr_addr_next   = clr_addr_reg;
        clr_active_next = clr_active_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (&clr_addr_reg) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            pc_reg         <= '0;
            started_reg    <= 1'b0;
            ex_valid_reg   <= 1'b0;
            mem_valid_reg  <= 1'b0;
            byp_valid_reg  <= 1'b0;
            rf_valid_reg   <= '0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            pc_reg         <= pc_next;
            started_reg    <= started_next;
            ex_valid_reg   <= s_accept;
            mem_valid_reg  <= ex_valid_reg;
            byp_valid_reg  <= rf_we;
            if (rf_we) begin
                rf_valid_reg[mem_res_reg.rd] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ex_instr_reg <= s_tdata;
        end
        if (ex_valid_reg) begin
            mem_res_reg <= ex_res;
        end
        if (rf_we) begin
            byp_rd_reg    <= mem_res_reg.rd;
            byp_value_reg <= wb_value;
        end
    end

endmodule

// ===== hw/rtl/rsie_checker.sv =====
// Port-level checks on the result stream of the execute block, with bind.
// Depends on rsie_pkg and riscv_subset_instruction_execute_macros.svh.
`include "riscv_subset_instruction_execute_macros.svh"

module rsie_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [rsie_pkg::M_TDATA_W-1:0] m_tdata
);

    rsie_pkg::result_t res;

    assign res = rsie_pkg::result_t'(m_tdata[rsie_pkg::RESULT_W-1:0]);

    `RSIE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    `RSIE_ASSERT_IMPLY(a_no_write_zero, aclk, aresetn, m_tvalid && !res.reg_written, res.dest_register == '0 && res.written_value == '0, "register fields set without a write")

    `RSIE_ASSERT_IMPLY(a_write_not_x0, aclk, aresetn, m_tvalid && res.reg_written, res.dest_register != '0 && !res.unsupported && res.memory_access != rsie_pkg::MEM_STORE, "bad register write report")

    `RSIE_ASSERT_IMPLY(a_unsup_quiet, aclk, aresetn, m_tvalid && (res.unsupported || res.memory_access == rsie_pkg::MEM_NONE), res.memory_index == '0 && (res.memory_access == rsie_pkg::MEM_NONE || !res.unsupported), "memory fields set without an access")

endmodule

bind riscv_subset_instruction_execute rsie_checker u_rsie_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
